>>> rtl/mqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqp_pkg
// Shared types and constants for the MQTT PUBLISH receive parser.
// ----------------------------------------------------------------------------
package mqp_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int PEND_W = 15;

  localparam logic REG_PAYLOAD_CAPACITY = 1'b0;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FAIL  = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_LEN1       = 3'd1,
    PH_LEN2       = 3'd2,
    PH_TOPIC_HI   = 3'd3,
    PH_TOPIC_LO   = 3'd4,
    PH_TOPIC_SKIP = 3'd5,
    PH_ID         = 3'd6,
    PH_PAYLOAD    = 3'd7
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        status;
    logic [7:0]  plen;
    logic [15:0] id;
    logic        retain;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage

>>> rtl/mqp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqp_parse
// Per-byte PUBLISH header walk; produces up to two results per transfer.
// ----------------------------------------------------------------------------
module mqp_parse #(
  parameter int MAX_BUFFER_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  input  logic               buffer_end,
  input  logic [7:0]         capacity,
  output mqp_pkg::parse_out_t res
);
  import mqp_pkg::*;

  phase_t              phase, phase_next;
  logic [7:0]          bytes_seen, bytes_seen_next;
  logic [13:0]         remaining_length, remaining_length_next;
  logic [PEND_W-1:0]   packet_end, packet_end_next;
  logic [7:0]          topic_left, topic_left_next;
  logic [1:0]          qos_level, qos_level_next;
  logic                retain_seen, retain_seen_next;
  logic [15:0]         id_value, id_value_next;
  logic                failed, failed_next;
  logic [7:0]          payload_count, payload_count_next;

  logic                in_pkt;
  logic                ok;
  logic [7:0]          tl_dec;
  result_t             pay_item, done_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      bytes_seen       <= '0;
      remaining_length <= '0;
      packet_end       <= '0;
      topic_left       <= '0;
      qos_level        <= '0;
      retain_seen      <= 1'b0;
      id_value         <= '0;
      failed           <= 1'b0;
      payload_count    <= '0;
    end else begin
      phase            <= phase_next;
      bytes_seen       <= bytes_seen_next;
      remaining_length <= remaining_length_next;
      packet_end       <= packet_end_next;
      topic_left       <= topic_left_next;
      qos_level        <= qos_level_next;
      retain_seen      <= retain_seen_next;
      id_value         <= id_value_next;
      failed           <= failed_next;
      payload_count    <= payload_count_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    bytes_seen_next       = bytes_seen;
    remaining_length_next = remaining_length;
    packet_end_next       = packet_end;
    topic_left_next       = topic_left;
    qos_level_next        = qos_level;
    retain_seen_next      = retain_seen;
    id_value_next         = id_value;
    failed_next           = failed;
    payload_count_next    = payload_count;
    in_pkt                = {{(PEND_W-8){1'b0}}, bytes_seen} < packet_end;
    tl_dec                = topic_left - 8'd1;
    ok                    = 1'b0;
    pay_item              = '0;
    done_item             = '0;
    res                   = '0;

    if (fire) begin
      if (bytes_seen >= 8'(MAX_BUFFER_BYTES)) begin
        failed_next = 1'b1;
      end else begin
        bytes_seen_next = bytes_seen + 8'd1;
        unique case (phase)
          PH_HEADER: begin
            qos_level_next = rx_byte[2:1];
            if (rx_byte[7:4] != 4'd3) begin
              failed_next = 1'b1;
            end else begin
              retain_seen_next = rx_byte[0];
            end
            if (rx_byte[2]) begin
              failed_next = 1'b1;
            end
            phase_next = PH_LEN1;
          end
          PH_LEN1: begin
            remaining_length_next = {7'd0, rx_byte[6:0]};
            if (rx_byte[7]) begin
              phase_next = PH_LEN2;
            end else begin
              packet_end_next = PEND_W'(2) + {{(PEND_W-7){1'b0}}, rx_byte[6:0]};
              phase_next      = PH_TOPIC_HI;
            end
          end
          PH_LEN2: begin
            if (rx_byte[7]) begin
              failed_next = 1'b1;
            end
            remaining_length_next = {rx_byte[6:0], remaining_length[6:0]};
            packet_end_next = PEND_W'(3) + {1'b0, rx_byte[6:0], remaining_length[6:0]};
            phase_next      = PH_TOPIC_HI;
          end
          PH_TOPIC_HI: begin
            if (in_pkt) begin
              if (rx_byte != 8'd0) begin
                failed_next = 1'b1;
              end
              phase_next = PH_TOPIC_LO;
            end
          end
          PH_TOPIC_LO: begin
            if (in_pkt) begin
              topic_left_next = rx_byte;
              if (rx_byte == 8'd0) begin
                if (qos_level != 2'd0) begin
                  topic_left_next = 8'd2;
                  phase_next      = PH_ID;
                end else begin
                  phase_next = PH_PAYLOAD;
                end
              end else begin
                phase_next = PH_TOPIC_SKIP;
              end
            end
          end
          PH_TOPIC_SKIP: begin
            if (in_pkt) begin
              topic_left_next = tl_dec;
              if (tl_dec == 8'd0) begin
                if (qos_level != 2'd0) begin
                  topic_left_next = 8'd2;
                  phase_next      = PH_ID;
                end else begin
                  phase_next = PH_PAYLOAD;
                end
              end
            end
          end
          PH_ID: begin
            if (in_pkt) begin
              id_value_next   = {id_value[7:0], rx_byte};
              topic_left_next = tl_dec;
              if (tl_dec == 8'd0) begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            if (in_pkt) begin
              if (!failed) begin
                pay_item.kind = KIND_PAYLOAD;
                pay_item.data = rx_byte;
                res.n         = 2'd1;
              end
              if (payload_count != 8'hff) begin
                payload_count_next = payload_count + 8'd1;
              end
            end
          end
          default: ;
        endcase
      end

      if (buffer_end) begin
        ok = !failed_next && (phase_next == PH_PAYLOAD) &&
             ({{(PEND_W-8){1'b0}}, bytes_seen_next} >= packet_end_next) &&
             (payload_count_next < capacity);
        done_item.kind   = KIND_DONE;
        done_item.status = ok ? STATUS_OK : STATUS_FAIL;
        done_item.plen   = ok ? payload_count_next : 8'd0;
        done_item.id     = (ok && qos_level_next == 2'd1) ? id_value_next : 16'd0;
        done_item.retain = (bytes_seen_next >= 8'd4) ? retain_seen_next : 1'b0;
        res.n            = res.n + 2'd1;

        phase_next            = PH_HEADER;
        bytes_seen_next       = '0;
        remaining_length_next = '0;
        packet_end_next       = '0;
        topic_left_next       = '0;
        qos_level_next        = '0;
        retain_seen_next      = 1'b0;
        id_value_next         = '0;
        failed_next           = 1'b0;
        payload_count_next    = '0;
      end
    end

    if (res.n == 2'd2) begin
      res.first  = pay_item;
      res.second = done_item;
    end else if (fire && buffer_end) begin
      res.first = done_item;
    end else begin
      res.first = pay_item;
    end
  end

  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    fire && buffer_end |=> phase == PH_HEADER && bytes_seen == 8'd0 && !failed)
    else $error("state not cleared after done");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    res.n == 2'd2 |-> res.first.kind == KIND_PAYLOAD && res.second.kind == KIND_DONE)
    else $error("bad result pair order");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    payload_count <= bytes_seen)
    else $error("payload count exceeds bytes seen");

endmodule

>>> rtl/mqp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqp_outq
// Small result queue; takes up to two results per cycle, drains one.
// ----------------------------------------------------------------------------
module mqp_outq (
  input  logic                clk,
  input  logic                rst,
  input  mqp_pkg::parse_out_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output mqp_pkg::result_t    head
);
  import mqp_pkg::*;

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  assign out_valid  = count != '0;
  assign pop        = out_valid && out_ready;
  assign space_ok   = count <= QCNT_W'(QDEPTH - 2);
  assign head       = mem[rd_ptr];
  assign count_next = count + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> space_ok)
    else $error("push without room");

  a_push_width: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd3)
    else $error("more than two results in one cycle");

endmodule

>>> rtl/mqtt_publish_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_publish_parser
// Receive-side check of one MQTT PUBLISH packet, one buffer byte per transfer.
//
// Input channel (in_valid/in_ready): rx_byte plus buffer_end on the last byte.
// Output channel (out_valid/out_ready): one result per transfer; item_kind 0
// is a payload byte, item_kind 1 the done item with status, payload_length,
// message_id and retain_flag. A byte may cause a payload item and a done item.
// Results of an accepted byte are registered into the queue before they appear.
// Throughput: one byte per cycle while results drain. Results go through a
// four-entry queue; in_ready is high while it has room for two, so a stalled
// receiver backs up the input once the queue holds more than two results.
// APB port: register 0 at address 0 is payload_capacity (reset 255).
// Reset (rst, synchronous) empties the queue and returns parsing to the
// header byte; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mqtt_publish_parser #(
  parameter int MAX_BUFFER_BYTES = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  input  logic                      buffer_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      item_kind,
  output logic [7:0]                payload_byte,
  output logic                      status,
  output logic [7:0]                payload_length,
  output logic [15:0]               message_id,
  output logic                      retain_flag,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mqp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mqp_pkg::*;

  logic       payload_capacity;
  logic [7:0] capacity;
  logic       fire;
  parse_out_t res;
  result_t    head;

  assign pready = 1'b1;
  assign fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 8'hff;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_PAYLOAD_CAPACITY: capacity <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign payload_capacity = paddr[2] == REG_PAYLOAD_CAPACITY;
  assign prdata = payload_capacity ? {24'd0, capacity} : 32'd0;

  mqp_parse #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx_byte),
    .buffer_end(buffer_end),
    .capacity  (capacity),
    .res       (res)
  );

  mqp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res),
    .space_ok (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign item_kind      = head.kind;
  assign payload_byte   = head.data;
  assign status         = head.status;
  assign payload_length = head.plen;
  assign message_id     = head.id;
  assign retain_flag    = head.retain;

endmodule

>>> sim/tb_mqtt_publish_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_publish_parser
// Feeds received buffers byte by byte into the PUBLISH parser and predicts
// every payload byte and done item with a cycle-free model of the parser.
// Covers header, length and topic errors, truncated and overlong buffers,
// trailing bytes, capacity limits and random traffic under three stall mixes.
// ----------------------------------------------------------------------------
module tb_mqtt_publish_parser;
  import mqp_pkg::*;

  localparam int MAX_BUFFER = 255;
  localparam int REG_UNUSED = 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic        status;
  logic [7:0]  payload_length;
  logic [15:0] message_id;
  logic        retain_flag;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  mqtt_publish_parser #(.MAX_BUFFER_BYTES(MAX_BUFFER)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .item_kind(item_kind), .payload_byte(payload_byte), .status(status),
    .payload_length(payload_length), .message_id(message_id),
    .retain_flag(retain_flag),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // parser shadow state
  logic [7:0]  capacity_shadow = 8'd255;
  phase_t      parse_phase;
  int          byte_count;
  int          rem_len;
  int          end_offset;
  logic [7:0]  topic_count;
  logic [1:0]  qos_bits;
  logic        retain_bit;
  logic [15:0] id_shadow;
  logic        reject;
  int          payload_bytes;

  result_t     parser_results_due[$];
  logic [7:0]  frame_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int payload_checked = 0;
  int packets_ok = 0;
  int packets_rejected = 0;
  int capacity_writes = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic void clear_parse_state();
    parse_phase = PH_HEADER;
    byte_count = 0;
    rem_len = 0;
    end_offset = 0;
    topic_count = 8'd0;
    qos_bits = 2'd0;
    retain_bit = 1'b0;
    id_shadow = 16'd0;
    reject = 1'b0;
    payload_bytes = 0;
  endfunction

  function automatic void enter_after_topic();
    if (qos_bits != 2'd0) begin
      topic_count = 8'd2;
      parse_phase = PH_ID;
    end else begin
      parse_phase = PH_PAYLOAD;
    end
  endfunction

  function automatic void predict_parser_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      idx;
    logic    accepted;
    if (byte_count >= MAX_BUFFER) begin
      reject = 1'b1;
    end else begin
      idx = byte_count;
      byte_count = (byte_count + 1) & 8'hff;
      case (parse_phase)
        PH_HEADER: begin
          qos_bits = b[2:1];
          if (b[7:4] != 4'd3) reject = 1'b1;
          else retain_bit = b[0];
          if (qos_bits > 2'd1) reject = 1'b1;
          parse_phase = PH_LEN1;
        end
        PH_LEN1: begin
          rem_len = int'(b[6:0]);
          if (b[7]) begin
            parse_phase = PH_LEN2;
          end else begin
            end_offset = 2 + rem_len;
            parse_phase = PH_TOPIC_HI;
          end
        end
        PH_LEN2: begin
          if (b[7]) reject = 1'b1;
          rem_len = (rem_len | (int'(b[6:0]) << 7)) & 14'h3fff;
          end_offset = 3 + rem_len;
          parse_phase = PH_TOPIC_HI;
        end
        default: begin
          if (idx < end_offset) begin
            case (parse_phase)
              PH_TOPIC_HI: begin
                if (b != 8'd0) reject = 1'b1;
                parse_phase = PH_TOPIC_LO;
              end
              PH_TOPIC_LO: begin
                topic_count = b;
                if (b == 8'd0) enter_after_topic();
                else parse_phase = PH_TOPIC_SKIP;
              end
              PH_TOPIC_SKIP: begin
                topic_count = topic_count - 8'd1;
                if (topic_count == 8'd0) enter_after_topic();
              end
              PH_ID: begin
                id_shadow = {id_shadow[7:0], b};
                topic_count = topic_count - 8'd1;
                if (topic_count == 8'd0) parse_phase = PH_PAYLOAD;
              end
              default: begin
                if (!reject) begin
                  r = '0;
                  r.kind = KIND_PAYLOAD;
                  r.data = b;
                  parser_results_due.push_back(r);
                end
                if (payload_bytes < 255) payload_bytes++;
              end
            endcase
          end
        end
      endcase
    end

    if (last) begin
      accepted = !reject && parse_phase == PH_PAYLOAD && byte_count >= end_offset &&
                 capacity_shadow != 8'd0 && payload_bytes < int'(capacity_shadow);
      r = '0;
      r.kind = KIND_DONE;
      r.status = accepted ? STATUS_OK : STATUS_FAIL;
      r.plen = accepted ? 8'(payload_bytes) : 8'd0;
      r.id = (accepted && qos_bits == 2'd1) ? id_shadow : 16'd0;
      r.retain = (byte_count >= 4) ? retain_bit : 1'b0;
      parser_results_due.push_back(r);
      clear_parse_state();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    buffer_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_parser_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic check_result();
    result_t due;
    if (parser_results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0b byte=%02h status=%0b",
                                item_kind, payload_byte, status));
    end else begin
      due = parser_results_due.pop_front();
      if (item_kind !== due.kind)
        report_mismatch($sformatf("item_kind %0b, want %0b", item_kind, due.kind));
      if (payload_byte !== due.data)
        report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte, due.data));
      if (status !== due.status)
        report_mismatch($sformatf("status %0b, want %0b", status, due.status));
      if (payload_length !== due.plen)
        report_mismatch($sformatf("payload_length %0d, want %0d", payload_length, due.plen));
      if (message_id !== due.id)
        report_mismatch($sformatf("message_id %04h, want %04h", message_id, due.id));
      if (retain_flag !== due.retain)
        report_mismatch($sformatf("retain_flag %0b, want %0b", retain_flag, due.retain));
      if (due.kind == KIND_PAYLOAD) payload_checked++;
      else if (due.status == STATUS_OK) packets_ok++;
      else packets_rejected++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    for (guard = 0; guard < 50000 && parser_results_due.size() != 0; guard++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (parser_results_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", parser_results_due.size()));
      parser_results_due.delete();
    end
  endtask

  task automatic write_register(input int index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (index == REG_PAYLOAD_CAPACITY) capacity_shadow = value[7:0];
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] cap);
    logic [31:0] readback;
    wait_idle();
    write_register(REG_PAYLOAD_CAPACITY, {24'd0, cap});
    capacity_writes++;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(4 * REG_PAYLOAD_CAPACITY);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {24'd0, capacity_shadow})
      report_mismatch($sformatf("payload_capacity reads %08h, want %02h",
                                readback, capacity_shadow));
    @(posedge clk);
  endtask

  task automatic build_publish(input logic [1:0] q, input logic ret, input int topic_n,
                               input int payload_n, input logic long_len);
    int rl;
    frame_bytes.delete();
    rl = 2 + topic_n + (q == 2'd1 ? 2 : 0) + payload_n;
    frame_bytes.push_back({4'h3, 1'b0, q, ret});
    if (rl < 128 && !long_len) begin
      frame_bytes.push_back(8'(rl));
    end else begin
      frame_bytes.push_back({1'b1, rl[6:0]});
      frame_bytes.push_back({1'b0, rl[13:7]});
    end
    frame_bytes.push_back(8'd0);
    frame_bytes.push_back(8'(topic_n));
    repeat (topic_n) frame_bytes.push_back(8'($urandom));
    if (q == 2'd1) begin
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
    end
    repeat (payload_n) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic make_random_frame();
    int pick;
    int tn;
    int pn;
    int cut;
    logic [1:0] q;
    pick = $urandom_range(99);
    if (pick < 5) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
      return;
    end
    q = (pick < 12) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    tn = ($urandom_range(9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40);
    case ($urandom_range(19))
      0, 1: pn = $urandom_range(25, 120);
      2: pn = $urandom_range(121, 240);
      default: pn = $urandom_range(0, 24);
    endcase
    build_publish(q, 1'($urandom), tn, pn, $urandom_range(9) == 0);
    pick = $urandom_range(99);
    if (pick < 10) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
    end else if (pick < 26) begin
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
    end
  endtask

  function automatic logic [7:0] pick_capacity();
    case ($urandom_range(3))
      0: return 8'd255;
      1: return 8'($urandom_range(1, 254));
      2: return 8'($urandom_range(0, 40));
      default: return 8'($urandom_range(200, 255));
    endcase
  endfunction

  task automatic test_directed_packets();
    frame_bytes = '{8'hFF};
    send_frame();
    // QoS 1 with retain, id all ones, one zero payload byte
    frame_bytes = '{8'h33, 8'h05, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send_frame();
    // one topic byte, payload 0x80, one byte past the packet end
    frame_bytes = '{8'h30, 8'h04, 8'h00, 8'h01, 8'h41, 8'h80, 8'hEE};
    send_frame();
    // second length byte with bit 7 set, buffer shorter than 4
    frame_bytes = '{8'h31, 8'h80, 8'h80};
    send_frame();
    frame_bytes = '{8'h36, 8'h00};
    send_frame();
    // nonzero topic length high byte
    frame_bytes = '{8'h31, 8'h02, 8'h01, 8'h00};
    send_frame();
  endtask

  task automatic test_capacity_limits();
    set_capacity(8'd0);
    build_publish(2'd0, 1'b0, 0, 0, 1'b0);
    send_frame();
    set_capacity(8'd1);
    build_publish(2'd1, 1'b1, 2, 0, 1'b0);
    send_frame();
    build_publish(2'd0, 1'b0, 0, 1, 1'b0);
    send_frame();
    set_capacity(8'd100);
    build_publish(2'd0, 1'b0, 3, 99, 1'b0);
    send_frame();
    build_publish(2'd1, 1'b0, 0, 100, 1'b0);
    send_frame();
    set_capacity(8'd255);
    build_publish(2'd0, 1'b1, 0, 250, 1'b0);
    send_frame();
    wait_idle();
    write_register(REG_UNUSED, 32'd0);
    build_publish(2'd0, 1'b0, 1, 5, 1'b1);
    send_frame();
  endtask

  task automatic test_overlong_buffer();
    set_capacity(8'd255);
    build_publish(2'd0, 1'b0, 0, 270, 1'b0);
    send_frame();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int byte_budget);
    int start;
    int frames;
    start = bytes_sent;
    frames = 0;
    set_capacity(pick_capacity());
    while (bytes_sent - start < byte_budget) begin
      make_random_frame();
      send_frame();
      frames++;
      if (frames % 25 == 0) set_capacity(pick_capacity());
    end
    wait_idle();
  endtask

  initial begin
    clear_parse_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 80;
    test_directed_packets();
    test_capacity_limits();
    test_overlong_buffer();
    test_random_traffic(300);
    send_idle_pct = 80;
    recv_idle_pct = 8;
    test_random_traffic(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers over %0d capacity settings.",
             bytes_sent, frames_sent, capacity_writes);
    $display("Checked %0d payload bytes, %0d packets accepted, %0d rejected.",
             payload_checked, packets_ok, packets_rejected);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: results still pending");
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/mqp_pkg.sv
rtl/mqp_parse.sv
rtl/mqp_outq.sv
rtl/mqtt_publish_parser.sv
sim/tb_mqtt_publish_parser.sv
